/* design/q824rsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q824rsq_pkg
// Shared types, constants and the seed function for the Q8.24 reciprocal
// square root pipeline.
// ----------------------------------------------------------------------------
package q824rsq_pkg;

    // Default seed index width (mantissa bits kept below the leading one)
    localparam int SEED_INDEX_BITS_DEFAULT = 7;

    // Operand classification limits
    localparam logic [30:0] SAT_LIMIT    = 31'd1024;
    localparam logic [30:0] DIRECT_LIMIT = 31'd1040;

    // 1.5 in Q8.24
    localparam logic [31:0] Q_ONE_POINT_FIVE = 32'd25165824;

    // Saturation values
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // Width of a raw seed table entry before the exponent shift
    localparam int BASE_W = 36;

    // Registered stages from input accept to result valid
    localparam int PIPE_LATENCY = 8;

    // Operand class
    typedef enum logic [1:0] {
        CLS_SAT,
        CLS_DIRECT,
        CLS_NEWTON
    } cls_t;

    // Decode stage to seed stage
    typedef struct packed {
        cls_t        cls;
        logic [3:0]  shift;
        logic [3:0]  dir_idx;
        logic [30:0] x;
    } dec_t;

    // Seed stage to Newton stage
    typedef struct packed {
        cls_t        cls;
        logic [30:0] y;
        logic [30:0] x;
    } seed_t;

    // Largest y with y*y*n <= 2^72, i.e. floor(2^36 / sqrt(n)).
    // Only evaluated on constants to build the seed tables.
    function automatic logic [BASE_W-1:0] seed_calc(input logic [15:0] n);
        logic [BASE_W-1:0] y;
        logic [BASE_W-1:0] c;
        logic [127:0]      prod;
        y = '0;
        for (int b = BASE_W - 1; b >= 0; b--) begin
            c    = y | (BASE_W'(1) << b);
            prod = 128'(c) * 128'(c) * 128'(n);
            if (prod <= (128'(1) << 72)) begin
                y = c;
            end
        end
        return y;
    endfunction

endpackage

/* design/q824rsq_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q824rsq_decode
// First pipeline stage: classifies the operand, finds its leading one and
// forms the seed table address and exponent shift.
// ----------------------------------------------------------------------------
module q824rsq_decode #(
    parameter int SEED_INDEX_BITS = q824rsq_pkg::SEED_INDEX_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [31:0]              value,
    input  logic                     in_valid,
    output logic                     in_ready,
    output q824rsq_pkg::dec_t        dec,
    output logic [SEED_INDEX_BITS:0] rom_addr,
    output logic                     out_valid,
    input  logic                     out_ready
);

    localparam logic [4:0] SIB5 = 5'(SEED_INDEX_BITS);

    logic                     valid_reg;
    q824rsq_pkg::dec_t        dec_reg;
    q824rsq_pkg::dec_t        dec_next;
    logic [SEED_INDEX_BITS:0] addr_reg;
    logic [SEED_INDEX_BITS:0] addr_next;
    logic [4:0]               lead;
    logic [4:0]               expo;
    logic [30:0]              mant_sh;
    logic                     en;

    // Stage advances when empty or when the next stage takes its item
    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Leading one of the magnitude bits
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 31; i++) begin
            if (value[i]) begin
                lead = 5'(i);
            end
        end
    end

    // Classification, table address and shift
    always_comb
    begin
        expo    = lead - SIB5;
        mant_sh = value[30:0] >> expo;
        if (value[31] || value[30:0] <= q824rsq_pkg::SAT_LIMIT) begin
            dec_next.cls = q824rsq_pkg::CLS_SAT;
        end else if (value[30:0] < q824rsq_pkg::DIRECT_LIMIT) begin
            dec_next.cls = q824rsq_pkg::CLS_DIRECT;
        end else begin
            dec_next.cls = q824rsq_pkg::CLS_NEWTON;
        end
        dec_next.shift   = expo[4:1];
        dec_next.dir_idx = value[3:0];
        dec_next.x       = value[31:1];
        addr_next        = {expo[0], mant_sh[SEED_INDEX_BITS-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid) begin
            dec_reg  <= dec_next;
            addr_reg <= addr_next;
        end
    end

    assign dec       = dec_reg;
    assign rom_addr  = addr_reg;
    assign out_valid = valid_reg;

endmodule

/* design/q824rsq_seed.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q824rsq_seed
// Seed lookup: registered ROM read of the mantissa seed and of the narrow
// direct band, then the exponent shift with saturation.
// ----------------------------------------------------------------------------
module q824rsq_seed #(
    parameter int SEED_INDEX_BITS = q824rsq_pkg::SEED_INDEX_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  q824rsq_pkg::dec_t        dec,
    input  logic [SEED_INDEX_BITS:0] rom_addr,
    input  logic                     in_valid,
    output logic                     in_ready,
    output q824rsq_pkg::seed_t       seed,
    output logic                     out_valid,
    input  logic                     out_ready
);

    localparam int ROM_DEPTH = 2 ** (SEED_INDEX_BITS + 1);
    localparam int MANT_ONE  = 2 ** SEED_INDEX_BITS;
    localparam int BW        = q824rsq_pkg::BASE_W;

    // Seed ROM: low half even exponent, high half odd exponent
    logic [BW-1:0] rom [ROM_DEPTH];
    // Direct band 1024..1039, saturated
    logic [30:0]   dtab [16];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam int M = MANT_ONE + (g % MANT_ONE);
        localparam int N = (g >= MANT_ONE) ? 2 * M : M;
        assign rom[g] = q824rsq_pkg::seed_calc(16'(N));
    end

    for (genvar g = 0; g < 16; g++) begin : g_dtab
        localparam logic [BW-1:0] D = q824rsq_pkg::seed_calc(16'(1024 + g));
        assign dtab[g] = (D > BW'(q824rsq_pkg::Q_MAX)) ? 31'h7FFF_FFFF : D[30:0];
    end

    logic                a_valid_reg;
    logic [BW-1:0]       a_base_reg;
    logic [30:0]         a_dir_reg;
    q824rsq_pkg::dec_t   a_dec_reg;
    logic                b_valid_reg;
    q824rsq_pkg::seed_t  b_seed_reg;
    q824rsq_pkg::seed_t  b_seed_next;
    logic [BW-1:0]       shifted;
    logic                en_a;
    logic                en_b;

    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Exponent shift and saturation to 31 bits
    always_comb
    begin
        shifted           = a_base_reg >> a_dec_reg.shift;
        b_seed_next.cls   = a_dec_reg.cls;
        b_seed_next.x     = a_dec_reg.x;
        if (a_dec_reg.cls == q824rsq_pkg::CLS_DIRECT) begin
            b_seed_next.y = a_dir_reg;
        end else if (|shifted[BW-1:31]) begin
            b_seed_next.y = 31'h7FFF_FFFF;
        end else begin
            b_seed_next.y = shifted[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a) begin
                a_valid_reg <= in_valid;
            end
            if (en_b) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // ROM read and stage payload
    always_ff @(posedge clk)
    begin
        if (en_a && in_valid) begin
            a_base_reg <= rom[rom_addr];
            a_dir_reg  <= dtab[dec.dir_idx];
            a_dec_reg  <= dec;
        end
        if (en_b && a_valid_reg) begin
            b_seed_reg <= b_seed_next;
        end
    end

    assign seed      = b_seed_reg;
    assign out_valid = b_valid_reg;

endmodule

/* design/q824rsq_newton.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q824rsq_newton
// One Newton-Raphson step y*(1.5 - (x*y)*y) over five register stages,
// three of them fed by a multiplier, plus final selection by operand class.
// ----------------------------------------------------------------------------
module q824rsq_newton (
    input  logic               clk,
    input  logic               rst_n,
    input  q824rsq_pkg::seed_t seed,
    input  logic               in_valid,
    output logic               in_ready,
    output logic [31:0]        result,
    output logic               out_valid,
    input  logic               out_ready
);

    logic                n1_valid_reg;
    logic [61:0]         n1_prod_reg;
    logic [30:0]         n1_y_reg;
    q824rsq_pkg::cls_t   n1_cls_reg;

    logic                n2_valid_reg;
    logic [61:0]         n2_prod_reg;
    logic [30:0]         n2_y_reg;
    q824rsq_pkg::cls_t   n2_cls_reg;

    logic                n3_valid_reg;
    logic [31:0]         n3_t_reg;
    logic [30:0]         n3_y_reg;
    q824rsq_pkg::cls_t   n3_cls_reg;

    logic                n4_valid_reg;
    logic signed [63:0]  n4_prod_reg;
    logic [30:0]         n4_y_reg;
    q824rsq_pkg::cls_t   n4_cls_reg;

    logic                n5_valid_reg;
    logic [31:0]         result_reg;
    logic [31:0]         result_next;

    logic [61:0]         n1_prod_next;
    logic [61:0]         n2_prod_next;
    logic signed [63:0]  n4_prod_next;
    logic [30:0]         p1;
    logic [30:0]         p2;
    logic [31:0]         t_next;
    logic signed [39:0]  s;
    logic [4:0]          en;

    // Per-stage advance; bubbles collapse
    assign en[4]    = !n5_valid_reg || out_ready;
    assign en[3]    = !n4_valid_reg || en[4];
    assign en[2]    = !n3_valid_reg || en[3];
    assign en[1]    = !n2_valid_reg || en[2];
    assign en[0]    = !n1_valid_reg || en[1];
    assign in_ready = en[0];

    // x*y
    assign n1_prod_next = 62'(seed.x) * 62'(seed.y);

    // floor(x*y >> 24) saturated, then times y
    assign p1           = (|n1_prod_reg[61:55]) ? 31'h7FFF_FFFF : n1_prod_reg[54:24];
    assign n2_prod_next = 62'(p1) * 62'(n1_y_reg);

    // saturate, then 1.5 - p2 with wrap
    assign p2     = (|n2_prod_reg[61:55]) ? 31'h7FFF_FFFF : n2_prod_reg[54:24];
    assign t_next = q824rsq_pkg::Q_ONE_POINT_FIVE - {1'b0, p2};

    // signed y*t
    assign n4_prod_next = $signed(n3_t_reg) * $signed({1'b0, n3_y_reg});

    // floor shift, saturate, select by class
    assign s = n4_prod_reg[63:24];
    always_comb
    begin
        case (n4_cls_reg)
            q824rsq_pkg::CLS_NEWTON: begin
                if (s[39:31] == 9'h000 || s[39:31] == 9'h1FF) begin
                    result_next = s[31:0];
                end else if (s[39]) begin
                    result_next = q824rsq_pkg::Q_MIN;
                end else begin
                    result_next = q824rsq_pkg::Q_MAX;
                end
            end
            q824rsq_pkg::CLS_DIRECT: result_next = {1'b0, n4_y_reg};
            default:                 result_next = q824rsq_pkg::Q_MAX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
            n3_valid_reg <= 1'b0;
            n4_valid_reg <= 1'b0;
            n5_valid_reg <= 1'b0;
        end else begin
            if (en[0]) n1_valid_reg <= in_valid;
            if (en[1]) n2_valid_reg <= n1_valid_reg;
            if (en[2]) n3_valid_reg <= n2_valid_reg;
            if (en[3]) n4_valid_reg <= n3_valid_reg;
            if (en[4]) n5_valid_reg <= n4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid) begin
            n1_prod_reg <= n1_prod_next;
            n1_y_reg    <= seed.y;
            n1_cls_reg  <= seed.cls;
        end
        if (en[1] && n1_valid_reg) begin
            n2_prod_reg <= n2_prod_next;
            n2_y_reg    <= n1_y_reg;
            n2_cls_reg  <= n1_cls_reg;
        end
        if (en[2] && n2_valid_reg) begin
            n3_t_reg    <= t_next;
            n3_y_reg    <= n2_y_reg;
            n3_cls_reg  <= n2_cls_reg;
        end
        if (en[3] && n3_valid_reg) begin
            n4_prod_reg <= n4_prod_next;
            n4_y_reg    <= n3_y_reg;
            n4_cls_reg  <= n3_cls_reg;
        end
        if (en[4] && n4_valid_reg) begin
            result_reg  <= result_next;
        end
    end

    assign result    = result_reg;
    assign out_valid = n5_valid_reg;

endmodule

/* design/q8_24_reciprocal_sqrt_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8_24_reciprocal_sqrt_top
// Approximate 1/sqrt of a signed Q8.24 operand, table seed plus one
// Newton-Raphson refinement, fully pipelined.
//
// Usage:
//   Input channel  value / value_valid / value_ready, output channel
//   result / result_valid / result_ready. An item moves on a clock edge
//   where valid and ready are both high; each operand gives one result,
//   in order.
//   Throughput: one item per cycle while result_ready is high. Registered
//   stages from accept to result_valid: 1 decode, 2 seed ROM and shift, 5 for the
//   three multiplies of the Newton step and the final saturation.
//   Operands <= 1024 (negatives included) give 0x7FFFFFFF; 1025..1039 come
//   straight from a 16-entry table.
//   Reset (rst_n low) empties the pipeline at once; no result is pending
//   afterwards. There is no configuration and no clearing pass.
//   When result_ready is low the output register holds its item; earlier
//   stages keep filling any empty slots, so value_ready drops only once
//   every stage holds an item.
// ----------------------------------------------------------------------------
module q8_24_reciprocal_sqrt_top #(
    parameter int SEED_INDEX_BITS = q824rsq_pkg::SEED_INDEX_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] value,
    input  logic        value_valid,
    output logic        value_ready,
    output logic [31:0] result,
    output logic        result_valid,
    input  logic        result_ready
);

    q824rsq_pkg::dec_t        dec;
    logic [SEED_INDEX_BITS:0] rom_addr;
    logic                     dec_valid;
    logic                     dec_ready;
    q824rsq_pkg::seed_t       seed;
    logic                     seed_valid;
    logic                     seed_ready;

    // Classify and form table address
    q824rsq_decode #(
        .SEED_INDEX_BITS (SEED_INDEX_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (value_valid),
        .in_ready  (value_ready),
        .dec       (dec),
        .rom_addr  (rom_addr),
        .out_valid (dec_valid),
        .out_ready (dec_ready)
    );

    // Seed lookup
    q824rsq_seed #(
        .SEED_INDEX_BITS (SEED_INDEX_BITS)
    ) u_seed (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec       (dec),
        .rom_addr  (rom_addr),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .seed      (seed),
        .out_valid (seed_valid),
        .out_ready (seed_ready)
    );

    // Newton step and output register
    q824rsq_newton u_newton (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed),
        .in_valid  (seed_valid),
        .in_ready  (seed_ready),
        .result    (result),
        .out_valid (result_valid),
        .out_ready (result_ready)
    );

endmodule

/* design/q824rsq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q824rsq_checker
// Port-level checks of the reciprocal square root pipeline: output hold,
// flow-through readiness, latency and saturation of negative operands.
// ----------------------------------------------------------------------------
module q824rsq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic [31:0] value,
    input logic        value_valid,
    input logic        value_ready,
    input logic [31:0] result,
    input logic        result_valid,
    input logic        result_ready
);

    localparam int LAT   = q824rsq_pkg::PIPE_LATENCY;
    localparam int RUN_W = $clog2(LAT + 1);

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic             flowing;

    // Consecutive edges with the receiver ready
    always_comb
    begin
        if (!result_ready) begin
            run_next = '0;
        end else if (run_reg == RUN_W'(LAT)) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= '0;
        end else begin
            run_reg <= run_next;
        end
    end

    assign flowing = (run_reg == RUN_W'(LAT));

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // Receiver ready lets the whole pipeline move
    a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> value_ready)
        else $error("input not ready while output is ready");

    // Fixed latency with no stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        flowing && $past(value_valid && value_ready, LAT) |-> result_valid)
        else $error("result missing after pipeline latency");

    // Negative operand saturates
    a_neg_sat: assert property (@(posedge clk) disable iff (!rst_n)
        flowing && $past(value_valid && value_ready && value[31], LAT)
        |-> result == q824rsq_pkg::Q_MAX)
        else $error("negative operand did not saturate");

endmodule

bind q8_24_reciprocal_sqrt_top q824rsq_checker u_checker (.*);

/* tb/sv/rsqrt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsqrt_checker
// Watches both channels of the Q8.24 reciprocal square root block. Every
// accepted operand is run through a local model (bit-exact seed search plus
// one Newton step) and queued. Every accepted result is compared with the
// oldest queued answer. Mismatch and queue depth go back to the top.
// ----------------------------------------------------------------------------
module rsqrt_checker #(
    parameter int SEED_BITS = q824rsq_pkg::SEED_INDEX_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] value,
    input  logic        value_valid,
    input  logic        value_ready,
    input  logic [31:0] result,
    input  logic        result_valid,
    input  logic        result_ready,
    output int          mismatches,
    output int          outstanding
);

    logic [31:0] pending_rsqrt[$];

    // Largest y with y*y*n <= 2^72, clipped to the Q8.24 maximum
    function automatic logic [31:0] seed_floor(input logic [31:0] n);
        logic [31:0]  y;
        logic [31:0]  c;
        logic [127:0] sq;
        y = '0;
        for (int b = 31; b >= 0; b--)
        begin
            c  = y | (32'd1 << b);
            sq = 128'(c) * 128'(c) * 128'(n);
            if (sq <= (128'd1 << 72))
                y = c;
        end
        if (y > q824rsq_pkg::Q_MAX)
            y = q824rsq_pkg::Q_MAX;
        return y;
    endfunction

    // Q8.24 multiply: full product, floor shift by 24, clip to 32 bits
    function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
        longint p;
        p = longint'($signed(a)) * longint'($signed(b));
        p = p >>> 24;
        if (p > 64'sh7FFF_FFFF)
            return q824rsq_pkg::Q_MAX;
        if (p < -64'sh8000_0000)
            return q824rsq_pkg::Q_MIN;
        return p[31:0];
    endfunction

    // Expected result for one operand
    function automatic logic [31:0] rsqrt_q824(input logic [31:0] raw);
        int          lead;
        int          lowb;
        logic [31:0] keep;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] t;
        if (raw[31] || raw <= 32'(q824rsq_pkg::SAT_LIMIT))
            return q824rsq_pkg::Q_MAX;
        if (raw < 32'(q824rsq_pkg::DIRECT_LIMIT))
            return seed_floor(raw);
        lead = 30;
        while (lead > 0 && !raw[lead])
            lead--;
        lowb = (lead >= SEED_BITS) ? lead - SEED_BITS : 0;
        keep = '0;
        for (int k = 0; k < 32; k++)
            keep[k] = (k <= lead) && (k >= lowb);
        y = seed_floor(raw & keep);
        x = {1'b0, raw[31:1]};
        t = q_mul(q_mul(x, y), y);
        // 1.5 - t wraps modulo 2^32
        t = q824rsq_pkg::Q_ONE_POINT_FIVE - t;
        return q_mul(y, t);
    endfunction

    // Compare departing results, then queue the answer for a new operand
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            pending_rsqrt.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_rsqrt.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = pending_rsqrt.pop_front();
                    if (result !== want)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, result);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (value_valid && value_ready)
                pending_rsqrt.push_back(rsqrt_q824(value));
            outstanding <= pending_rsqrt.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives operands into the Q8.24 reciprocal square root block: corner
// values first, then a random mix weighted toward each operand class, under
// three traffic profiles. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_PER_PHASE = 560;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic [31:0] value        = '0;
    logic        value_valid  = 1'b0;
    logic        value_ready;
    logic [31:0] result;
    logic        result_valid;
    logic        result_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches;
    int outstanding;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    q8_24_reciprocal_sqrt_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .value_valid  (value_valid),
        .value_ready  (value_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    rsqrt_checker #(
        .SEED_BITS (q824rsq_pkg::SEED_INDEX_BITS_DEFAULT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .value_valid  (value_valid),
        .value_ready  (value_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Output side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one operand, with optional idle cycles ahead of it
    task automatic send_operand(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            value_valid <= 1'b0;
            @(posedge clk);
        end
        value       <= v;
        value_valid <= 1'b1;
        @(posedge clk);
        while (!value_ready)
            @(posedge clk);
    endtask

    // Random operand, weighted toward the interesting classes
    function automatic logic [31:0] random_operand();
        int          pick;
        int          e;
        logic [31:0] v;
        pick = $urandom_range(99);
        e    = $urandom_range(10, 30);
        if (pick < 40)
            v = (32'd1 << e) | ($urandom & ((32'd1 << e) - 1));
        else if (pick < 55)
            v = $urandom;
        else if (pick < 70)
            v = $urandom_range(1000, 1100);
        else if (pick < 80)
            v = $urandom | 32'h8000_0000;
        else if (pick < 90)
            v = (32'd1 << e) + $urandom_range(0, 2) - 1;
        else
            v = $urandom_range(0, 2048);
        return v;
    endfunction

    // Stimulus and verdict
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 32; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 32; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase == 0)
            begin
                // zero, tiny, negative and full-scale corners
                send_operand(32'h0000_0000);
                send_operand(32'h0000_0001);
                send_operand(32'hFFFF_FFFF);
                send_operand(32'h8000_0000);
                send_operand(32'hFFFF_FBFF);
                send_operand(32'h7FFF_FFFF);
                // edges of the saturated, table and Newton ranges
                send_operand(32'd1024);
                send_operand(32'd1025);
                send_operand(32'd1032);
                send_operand(32'd1039);
                send_operand(32'd1040);
                send_operand(32'd1041);
                send_operand(32'd2047);
                send_operand(32'd2048);
                // around 1.0, 4.0 and the top bit of the magnitude
                send_operand(32'h00FF_FFFF);
                send_operand(32'h0100_0000);
                send_operand(32'h01FF_FFFF);
                send_operand(32'h0400_0000);
                send_operand(32'h3FFF_FFFF);
                send_operand(32'h4000_0000);
                send_operand(32'h5555_5555);
                send_operand(32'h2AAA_AAAA);
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_operand(random_operand());
        end
        value_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * q824rsq_pkg::PIPE_LATENCY) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
design/q824rsq_pkg.sv
design/q824rsq_decode.sv
design/q824rsq_seed.sv
design/q824rsq_newton.sv
design/q8_24_reciprocal_sqrt_top.sv
design/q824rsq_checker.sv
tb/sv/rsqrt_checker.sv
tb/sv/testbench.sv
